// ----- sv/rarmt_pkg.sv -----
// ----------------------------------------------------------------------------
// Range add / range minimum tree: shared package
// Constants and item kind codes used by the tree core and its node memory.
// ----------------------------------------------------------------------------
`default_nettype none

package rarmt_pkg;

    // Default number of positions the tree can hold.
    localparam int unsigned MAX_POSITIONS_DEF = 1024;

    // Fixed field widths of the stream payload.
    localparam int unsigned KIND_W  = 2;
    localparam int unsigned POS_W   = 11;
    localparam int unsigned VALUE_W = 32;

    // Answer for a query over an empty range.
    localparam logic [VALUE_W-1:0] EMPTY_MIN = 32'h3f3f3f3f;

    // Item kinds.
    localparam logic [KIND_W-1:0] KIND_LOAD  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ADD   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_QUERY = 2'd2;

    typedef logic signed [VALUE_W-1:0] value_t;

    // Signed minimum of two node values.
    function automatic logic [VALUE_W-1:0] smin(input logic [VALUE_W-1:0] a,
                                                input logic [VALUE_W-1:0] b);
        return ($signed(b) < $signed(a)) ? b : a;
    endfunction

endpackage

`default_nettype wire

// ----- sv/rarmt_node_mem.sv -----
// ----------------------------------------------------------------------------
// Range add / range minimum tree: node memory
// Two synchronous arrays, node minima and pending adds, with one shared read
// address and one shared write address; read data is registered.
// ----------------------------------------------------------------------------
`default_nettype none

module rarmt_node_mem
    import rarmt_pkg::*;
#(
    parameter int unsigned DEPTH = 4 * MAX_POSITIONS_DEF,
    parameter int unsigned AW    = $clog2(DEPTH)
) (
    input  wire logic               aclk,
    input  wire logic [AW-1:0]      rd_addr,
    output logic [VALUE_W-1:0]      rd_min,
    output logic [VALUE_W-1:0]      rd_pend,
    input  wire logic               wr_min_en,
    input  wire logic               wr_pend_en,
    input  wire logic [AW-1:0]      wr_addr,
    input  wire logic [VALUE_W-1:0] wr_min,
    input  wire logic [VALUE_W-1:0] wr_pend
);

    logic [VALUE_W-1:0] min_mem  [DEPTH];
    logic [VALUE_W-1:0] pend_mem [DEPTH];

    // Minimum array: one write and one registered read per cycle.
    always_ff @(posedge aclk) begin
        if (wr_min_en) begin
            min_mem[wr_addr] <= wr_min;
        end
        rd_min <= min_mem[rd_addr];
    end

    // Pending-add array.
    always_ff @(posedge aclk) begin
        if (wr_pend_en) begin
            pend_mem[wr_addr] <= wr_pend;
        end
        rd_pend <= pend_mem[rd_addr];
    end

endmodule

`default_nettype wire

// ----- sv/range_add_range_min_tree_core.sv -----
// ----------------------------------------------------------------------------
// Range add / range minimum tree core
// Lazy segment tree over positions 1..active_size held in node memory; a
// sequencer walks the tree with an explicit stack, one node at a time.
// ----------------------------------------------------------------------------
//  Channel   Direction  Payload
//  s_        in         tuser: kind; tdata: range_low, range_high, value
//  m_        out        tdata: minimum; tuser: was_query
//  cfg_      in         wr_data: active_size
//
//  Each item walks the tree from the root; every node the walk splits hands its
//  pending add down to both children and then, but for a query, pulls its minimum back up.
//  The node memory has one read and one write port with a registered read.
//  After reset a sweep clears the pending adds of all 4 * MAX_POSITIONS nodes;
//  no beat is accepted during it.
//  A finished result waits in the output register while the next beat is
//  taken; the walk stalls at its end until that register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module range_add_range_min_tree_core
    import rarmt_pkg::*;
#(
    parameter int unsigned MAX_POSITIONS = MAX_POSITIONS_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [55:0] s_tdata,   // range_low, range_high, value, zero pad
    input  wire logic [1:0]  s_tuser,   // kind
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // minimum
    output logic             m_tuser,   // was_query
    input  wire logic        cfg_wr_en,
    input  wire logic [10:0] cfg_wr_data
);

    localparam int unsigned DEPTH = 4 * MAX_POSITIONS;
    localparam int unsigned NW    = $clog2(DEPTH);
    localparam int unsigned PW    = $clog2(MAX_POSITIONS + 1);
    localparam int unsigned CW    = (PW > POS_W) ? PW : POS_W;
    localparam int unsigned SD    = $clog2(MAX_POSITIONS) + 2;
    localparam int unsigned SIW   = $clog2(SD);
    localparam int unsigned SPW   = $clog2(SD + 1);

    localparam logic [CW-1:0] MAX_C = CW'(MAX_POSITIONS);
    localparam logic [CW-1:0] ONE_C = CW'(1);

    // Sequencer states.
    localparam logic [3:0] S_CLEAR   = 4'd0;
    localparam logic [3:0] S_IDLE    = 4'd1;
    localparam logic [3:0] S_RD_NODE = 4'd2;
    localparam logic [3:0] S_NODE    = 4'd3;
    localparam logic [3:0] S_PUSH_L  = 4'd4;
    localparam logic [3:0] S_PUSH_R  = 4'd5;
    localparam logic [3:0] S_DESCEND = 4'd6;
    localparam logic [3:0] S_PULL_L  = 4'd7;
    localparam logic [3:0] S_PULL_R  = 4'd8;
    localparam logic [3:0] S_RETURN  = 4'd9;
    localparam logic [3:0] S_DONE    = 4'd10;

    logic [3:0]         state_reg, state_next;
    logic [10:0]        size_reg;
    logic [NW-1:0]      clr_reg, clr_next;
    logic [KIND_W-1:0]  kind_reg, kind_next;
    logic [CW-1:0]      s_reg, s_next, e_reg, e_next;
    logic [VALUE_W-1:0] val_reg, val_next, best_reg, best_next;
    logic [VALUE_W-1:0] t_reg, t_next, lmin_reg, lmin_next;
    logic [NW-1:0]      x_reg, x_next;
    logic [CW-1:0]      lo_reg, lo_next, hi_reg, hi_next;
    logic [1:0]         step_reg, step_next;
    logic [SPW-1:0]     sp_reg, sp_next;
    logic               m_valid_reg, m_valid_next;
    logic [VALUE_W-1:0] m_min_reg, m_min_next;
    logic               m_query_reg, m_query_next;

    logic [NW-1:0]      stk_x    [SD];
    logic [CW-1:0]      stk_lo   [SD];
    logic [CW-1:0]      stk_hi   [SD];
    logic [1:0]         stk_step [SD];
    logic               stk_push;

    // Node memory port signals.
    logic [NW-1:0]      rd_addr, wr_addr;
    logic [VALUE_W-1:0] rd_min, rd_pend, wr_min, wr_pend;
    logic               wr_min_en, wr_pend_en;

    // Derived node values.
    logic [NW-1:0]      lchild, rchild;
    logic [CW:0]        mid_sum;
    logic [CW-1:0]      mid;
    logic               covered, go_left, go_right;
    logic [SPW-1:0]     sp_dec;

    // Input decode.
    logic [CW-1:0]      in_lo, in_hi, size_c, n_c, in_s, in_e;
    logic               in_load_ok, in_range_ok, in_active;

    assign lchild   = {x_reg[NW-2:0], 1'b0};
    assign rchild   = {x_reg[NW-2:0], 1'b1};
    assign mid_sum  = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid      = mid_sum[CW:1];
    assign covered  = (s_reg <= lo_reg) && (hi_reg <= e_reg);
    assign go_left  = (s_reg <= mid);
    assign go_right = (e_reg > mid);
    assign sp_dec   = sp_reg - SPW'(1);

    assign in_lo    = CW'(s_tdata[10:0]);
    assign in_hi    = CW'(s_tdata[21:11]);
    assign size_c   = CW'(size_reg);
    assign n_c      = (size_c == '0) ? ONE_C : ((size_c > MAX_C) ? MAX_C : size_c);
    assign in_s     = (in_lo == '0) ? ONE_C : in_lo;
    assign in_e     = (in_hi > n_c) ? n_c : in_hi;
    assign in_load_ok  = (in_lo != '0) && (in_lo <= n_c);
    assign in_range_ok = (in_s <= in_e);
    assign in_active   = ((s_tuser == KIND_LOAD) && in_load_ok) ||
                         (((s_tuser == KIND_ADD) || (s_tuser == KIND_QUERY)) && in_range_ok);

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_min_reg;
    assign m_tuser  = m_query_reg;

    rarmt_node_mem #(
        .DEPTH (DEPTH),
        .AW    (NW)
    ) u_node_mem (
        .aclk       (aclk),
        .rd_addr    (rd_addr),
        .rd_min     (rd_min),
        .rd_pend    (rd_pend),
        .wr_min_en  (wr_min_en),
        .wr_pend_en (wr_pend_en),
        .wr_addr    (wr_addr),
        .wr_min     (wr_min),
        .wr_pend    (wr_pend)
    );

    // Sequencer: walks the tree, issues memory reads and write-backs.
    always_comb begin
        state_next   = state_reg;
        clr_next     = clr_reg;
        kind_next    = kind_reg;
        s_next       = s_reg;
        e_next       = e_reg;
        val_next     = val_reg;
        best_next    = best_reg;
        t_next       = t_reg;
        lmin_next    = lmin_reg;
        x_next       = x_reg;
        lo_next      = lo_reg;
        hi_next      = hi_reg;
        step_next    = step_reg;
        sp_next      = sp_reg;
        stk_push     = 1'b0;
        m_valid_next = m_valid_reg && !m_tready;
        m_min_next   = m_min_reg;
        m_query_next = m_query_reg;
        rd_addr      = x_reg;
        wr_addr      = x_reg;
        wr_min       = rd_min;
        wr_pend      = rd_pend;
        wr_min_en    = 1'b0;
        wr_pend_en   = 1'b0;

        unique case (state_reg)
            S_CLEAR: begin
                wr_addr    = clr_reg;
                wr_pend    = '0;
                wr_pend_en = 1'b1;
                clr_next   = clr_reg + NW'(1);
                if (clr_reg == NW'(DEPTH - 1)) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_tvalid) begin
                    kind_next = s_tuser;
                    val_next  = s_tdata[53:22];
                    best_next = EMPTY_MIN;
                    s_next    = (s_tuser == KIND_LOAD) ? in_lo : in_s;
                    e_next    = (s_tuser == KIND_LOAD) ? in_lo : in_e;
                    x_next    = NW'(1);
                    lo_next   = ONE_C;
                    hi_next   = n_c;
                    step_next = 2'd0;
                    sp_next   = '0;
                    state_next = in_active ? S_RD_NODE : S_DONE;
                end
            end
            S_RD_NODE: begin
                state_next = S_NODE;
            end
            S_NODE: begin
                if (covered) begin
                    case (kind_reg)
                        KIND_LOAD: begin
                            wr_min     = val_reg;
                            wr_pend    = '0;
                            wr_min_en  = 1'b1;
                            wr_pend_en = 1'b1;
                        end
                        KIND_ADD: begin
                            wr_min     = rd_min + val_reg;
                            wr_pend    = rd_pend + val_reg;
                            wr_min_en  = 1'b1;
                            wr_pend_en = 1'b1;
                        end
                        default: begin
                            // A range that covers the root answers its minimum as it
                            // stands; below a split the answer is capped by the empty value.
                            best_next = (sp_reg == '0) ? rd_min : smin(best_reg, rd_min);
                        end
                    endcase
                    state_next = S_RETURN;
                end else begin
                    // Hand the pending add down to both children.
                    t_next     = rd_pend;
                    wr_pend    = '0;
                    wr_pend_en = 1'b1;
                    rd_addr    = lchild;
                    step_next  = 2'd0;
                    state_next = S_PUSH_L;
                end
            end
            S_PUSH_L: begin
                wr_addr    = lchild;
                wr_min     = rd_min + t_reg;
                wr_pend    = rd_pend + t_reg;
                wr_min_en  = 1'b1;
                wr_pend_en = 1'b1;
                rd_addr    = rchild;
                state_next = S_PUSH_R;
            end
            S_PUSH_R: begin
                wr_addr    = rchild;
                wr_min     = rd_min + t_reg;
                wr_pend    = rd_pend + t_reg;
                wr_min_en  = 1'b1;
                wr_pend_en = 1'b1;
                state_next = S_DESCEND;
            end
            S_DESCEND: begin
                if (step_reg == 2'd0) begin
                    if (go_left) begin
                        stk_push   = 1'b1;
                        step_next  = 2'd0;
                        sp_next    = sp_reg + SPW'(1);
                        x_next     = lchild;
                        hi_next    = mid;
                        state_next = S_RD_NODE;
                    end else begin
                        step_next = 2'd1;
                    end
                end else if (step_reg == 2'd1) begin
                    if (go_right) begin
                        stk_push   = 1'b1;
                        step_next  = 2'd0;
                        sp_next    = sp_reg + SPW'(1);
                        x_next     = rchild;
                        lo_next    = mid + ONE_C;
                        state_next = S_RD_NODE;
                    end else begin
                        step_next = 2'd2;
                    end
                end else if (kind_reg == KIND_QUERY) begin
                    state_next = S_RETURN;
                end else begin
                    // Recompute this node's minimum from its children.
                    rd_addr    = lchild;
                    state_next = S_PULL_L;
                end
            end
            S_PULL_L: begin
                lmin_next  = rd_min;
                rd_addr    = rchild;
                state_next = S_PULL_R;
            end
            S_PULL_R: begin
                wr_min     = smin(lmin_reg, rd_min);
                wr_min_en  = 1'b1;
                state_next = S_RETURN;
            end
            S_RETURN: begin
                if (sp_reg == '0) begin
                    state_next = S_DONE;
                end else begin
                    sp_next    = sp_dec;
                    x_next     = stk_x[sp_dec[SIW-1:0]];
                    lo_next    = stk_lo[sp_dec[SIW-1:0]];
                    hi_next    = stk_hi[sp_dec[SIW-1:0]];
                    step_next  = stk_step[sp_dec[SIW-1:0]];
                    state_next = S_DESCEND;
                end
            end
            S_DONE: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_query_next = (kind_reg == KIND_QUERY);
                    m_min_next   = (kind_reg == KIND_QUERY) ? best_reg : '0;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            clr_reg     <= '0;
            sp_reg      <= '0;
            m_valid_reg <= 1'b0;
            size_reg    <= 11'd1024;
        end else begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            sp_reg      <= sp_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en) begin
                size_reg <= cfg_wr_data;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        kind_reg    <= kind_next;
        s_reg       <= s_next;
        e_reg       <= e_next;
        val_reg     <= val_next;
        best_reg    <= best_next;
        t_reg       <= t_next;
        lmin_reg    <= lmin_next;
        x_reg       <= x_next;
        lo_reg      <= lo_next;
        hi_reg      <= hi_next;
        step_reg    <= step_next;
        m_min_reg   <= m_min_next;
        m_query_reg <= m_query_next;
    end

    // Walk stack: the parent frame is saved on each descent.
    always_ff @(posedge aclk) begin
        if (stk_push) begin
            stk_x[sp_reg[SIW-1:0]]    <= x_reg;
            stk_lo[sp_reg[SIW-1:0]]   <= lo_reg;
            stk_hi[sp_reg[SIW-1:0]]   <= hi_reg;
            stk_step[sp_reg[SIW-1:0]] <= step_reg + 2'd1;
        end
    end

    // The stack never grows past the tree depth.
    a_sp_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        sp_reg <= SPW'(SD))
        else $error("walk stack overflow");

    // An accepted beat always starts a walk or a result.
    a_accept_leaves_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (state_reg == S_RD_NODE || state_reg == S_DONE))
        else $error("accepted beat did not start work");

    // No result appears during the clearing sweep.
    a_clear_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_CLEAR) |-> (!s_tready && !m_valid_reg))
        else $error("activity during clearing sweep");

    // A new result is loaded only from the finishing state.
    a_out_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == S_DONE))
        else $error("result raised outside finish state");

endmodule

`default_nettype wire

// ----- dv/tb_top.sv -----
// ----------------------------------------------------------------------------
// Range add / range minimum tree: testbench
// Drives loads, range adds and range minimum queries through the input
// stream; each result beat is checked against a directed row's own answer or a
// lazy segment tree kept in the testbench. A short directed table comes first,
// then random phases at several tree sizes; random idle bursts on both streams.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top
    import rarmt_pkg::*;
();

    localparam int unsigned TREE_NODES = 4 * MAX_POSITIONS_DEF;

    // One expected result beat.
    typedef struct {
        logic [31:0] minimum;
        logic        was_query;
    } answer_t;

    // One row of the directed table.
    typedef struct {
        logic [1:0]  kind;
        logic [10:0] lo;
        logic [10:0] hi;
        logic [31:0] value;
        bit          typed;
        logic [31:0] minimum;
        logic        was_query;
    } row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [55:0] s_tdata = '0;   // range_low, range_high, value, zero pad
    logic [1:0]  s_tuser = '0;   // kind
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;        // minimum
    logic        m_tuser;        // was_query
    logic        cfg_wr_en = 1'b0;
    logic [10:0] cfg_wr_data = '0;

    // Testbench copy of the tree.
    logic [31:0] node_min [TREE_NODES];
    logic [31:0] node_add [TREE_NODES];
    logic [10:0] size_reg = 11'd1024;

    answer_t     answers_due [$];
    int          error_count = 0;
    int          beats_seen = 0;
    bit          quiet = 1'b0;

    range_add_range_min_tree_core dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Hard stop in case the block hangs.
    initial begin
        #20000000;
        $display("simulation failed");
        $finish;
    end

    // Signed minimum of two node values.
    function automatic logic [31:0] lesser(input logic [31:0] a, input logic [31:0] b);
        return ($signed(b) < $signed(a)) ? b : a;
    endfunction

    // Hand a pending add down to both children.
    function automatic void push_down(input int unsigned x);
        logic [31:0] t;
        t = node_add[x];
        if (t == 0)
            return;
        if (2 * x + 1 < TREE_NODES) begin
            node_min[2 * x]     += t;
            node_add[2 * x]     += t;
            node_min[2 * x + 1] += t;
            node_add[2 * x + 1] += t;
        end
        node_add[x] = 0;
    endfunction

    function automatic void pull_up(input int unsigned x);
        if (2 * x + 1 < TREE_NODES)
            node_min[x] = lesser(node_min[2 * x], node_min[2 * x + 1]);
    endfunction

    function automatic void load_node(input int unsigned x, input int unsigned lo,
                                      input int unsigned hi, input int unsigned pos,
                                      input logic [31:0] v);
        int unsigned mid;
        if (x >= TREE_NODES)
            return;
        if (lo == hi) begin
            node_min[x] = v;
            node_add[x] = 0;
            return;
        end
        push_down(x);
        mid = (lo + hi) >> 1;
        if (pos <= mid)
            load_node(2 * x, lo, mid, pos, v);
        else
            load_node(2 * x + 1, mid + 1, hi, pos, v);
        pull_up(x);
    endfunction

    function automatic void add_node(input int unsigned x, input int unsigned lo,
                                     input int unsigned hi, input int unsigned s,
                                     input int unsigned e, input logic [31:0] v);
        int unsigned mid;
        if (x >= TREE_NODES)
            return;
        if (s <= lo && hi <= e) begin
            node_min[x] += v;
            node_add[x] += v;
            return;
        end
        push_down(x);
        mid = (lo + hi) >> 1;
        if (s <= mid)
            add_node(2 * x, lo, mid, s, e, v);
        if (e > mid)
            add_node(2 * x + 1, mid + 1, hi, s, e, v);
        pull_up(x);
    endfunction

    function automatic logic [31:0] min_node(input int unsigned x, input int unsigned lo,
                                             input int unsigned hi, input int unsigned s,
                                             input int unsigned e);
        int unsigned mid;
        logic [31:0] best;
        best = EMPTY_MIN;
        if (x >= TREE_NODES)
            return EMPTY_MIN;
        if (s <= lo && hi <= e)
            return node_min[x];
        push_down(x);
        mid = (lo + hi) >> 1;
        if (s <= mid)
            best = lesser(best, min_node(2 * x, lo, mid, s, e));
        if (e > mid)
            best = lesser(best, min_node(2 * x + 1, mid + 1, hi, s, e));
        return best;
    endfunction

    function automatic int unsigned used_size(input logic [10:0] r);
        if (r == 0)
            return 1;
        if (r > MAX_POSITIONS_DEF)
            return MAX_POSITIONS_DEF;
        return r;
    endfunction

    // Apply one item to the tree copy and return the answer it produces.
    function automatic answer_t tree_answer(input logic [1:0] kind, input logic [10:0] lo,
                                            input logic [10:0] hi, input logic [31:0] v);
        answer_t a;
        int unsigned n, s, e;
        n = used_size(size_reg);
        s = (lo < 1) ? 1 : lo;
        e = (hi > n) ? n : hi;
        a.minimum = 0;
        a.was_query = 1'b0;
        if (kind == KIND_LOAD) begin
            if (lo >= 1 && lo <= n)
                load_node(1, 1, n, lo, v);
        end else if (kind == KIND_ADD) begin
            if (s <= e)
                add_node(1, 1, n, s, e, v);
        end else if (kind == KIND_QUERY) begin
            a.minimum = (s <= e) ? min_node(1, 1, n, s, e) : EMPTY_MIN;
            a.was_query = 1'b1;
        end
        return a;
    endfunction

    // Offer one beat, wait for its acceptance, then record what it should yield.
    task automatic send_item(input logic [1:0] kind, input logic [10:0] lo,
                             input logic [10:0] hi, input logic [31:0] v,
                             input bit typed, input answer_t typed_ans);
        answer_t a;
        int gap;
        if (!quiet && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 3);
            repeat (gap) begin
                @(negedge aclk);
                s_tvalid = 1'b0;
            end
        end
        @(negedge aclk);
        s_tvalid = 1'b1;
        s_tuser  = kind;
        s_tdata  = {2'b00, v, hi, lo};
        forever begin
            @(posedge aclk);
            if (s_tready)
                break;
        end
        a = tree_answer(kind, lo, hi, v);
        answers_due.push_back(typed ? typed_ans : a);
    endtask

    task automatic go_idle();
        @(negedge aclk);
        s_tvalid = 1'b0;
    endtask

    // Let every outstanding result arrive, then give the walk time to finish.
    task automatic drain();
        go_idle();
        while (answers_due.size() != 0)
            @(posedge aclk);
        repeat (400) @(posedge aclk);
    endtask

    task automatic write_size(input logic [10:0] v);
        @(negedge aclk);
        cfg_wr_en   = 1'b1;
        cfg_wr_data = v;
        @(negedge aclk);
        cfg_wr_en = 1'b0;
        size_reg  = v;
    endtask

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 7))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2, 3:    return 32'($urandom_range(0, 400)) - 32'd200;
            default: return $urandom;
        endcase
    endfunction

    // Random phase: load every position first, then mixed operations.
    task automatic run_phase(input logic [10:0] reg_val, input int ops);
        int unsigned n, lo, hi;
        int r;
        answer_t none;
        none = '{minimum: 0, was_query: 0};
        write_size(reg_val);
        n = used_size(reg_val);
        for (int unsigned p = 1; p <= n; p++)
            send_item(KIND_LOAD, 11'(p), 11'($urandom), pick_value(), 0, none);
        for (int i = 0; i < ops; i++) begin
            r  = $urandom_range(0, 99);
            lo = $urandom_range(1, n);
            hi = ($urandom_range(0, 3) == 0) ? $urandom_range(lo, n) :
                 ((lo + $urandom_range(0, 8) > n) ? n : lo + $urandom_range(0, 8));
            if (r < 40)
                send_item(KIND_QUERY, 11'(lo), 11'(hi), $urandom, 0, none);
            else if (r < 72)
                send_item(KIND_ADD, 11'(lo), 11'(hi), pick_value(), 0, none);
            else if (r < 84)
                send_item(KIND_LOAD, 11'(lo), 11'($urandom), pick_value(), 0, none);
            else if (r < 90)
                send_item(KIND_LOAD, ($urandom_range(0, 1) != 0) ? 11'd0 :
                          11'($urandom_range(n + 1, 2047)), 11'($urandom), $urandom, 0, none);
            else if (r < 94)
                send_item(2'd3, 11'($urandom), 11'($urandom), $urandom, 0, none);
            else
                send_item(($urandom_range(0, 1) != 0) ? KIND_QUERY : KIND_ADD,
                          11'($urandom), 11'($urandom), pick_value(), 0, none);
        end
        drain();
    endtask

    // Result side: random stall bursts, one long hold, and the field checks.
    initial begin
        answer_t want;
        int hold;
        bit long_done;
        hold = 0;
        long_done = 0;
        forever begin
            @(posedge aclk);
            if (m_tvalid && m_tready) begin
                beats_seen++;
                if (answers_due.size() == 0) begin
                    $error("result beat with nothing expected: minimum %h", m_tdata);
                    error_count++;
                end else begin
                    want = answers_due.pop_front();
                    if (m_tdata !== want.minimum) begin
                        $error("minimum: expected %h, actual %h", want.minimum, m_tdata);
                        error_count++;
                    end
                    if (m_tuser !== want.was_query) begin
                        $error("was_query: expected %b, actual %b", want.was_query, m_tuser);
                        error_count++;
                    end
                end
            end
            @(negedge aclk);
            if (!long_done && beats_seen >= 300) begin
                long_done = 1;
                hold = 3000;
            end else if (hold == 0 && !quiet && $urandom_range(0, 5) == 0) begin
                hold = $urandom_range(1, 3);
            end
            if (hold > 0) begin
                hold--;
                m_tready = 1'b0;
            end else begin
                m_tready = 1'b1;
            end
        end
    end

    // Stimulus.
    initial begin
        row_t rows [$];
        answer_t ans;
        rows = '{
            '{KIND_LOAD,  11'd1,    11'd0,    32'h8000_0000, 1, 32'd0, 1'b0},
            '{KIND_LOAD,  11'd2,    11'd0,    32'h7fff_ffff, 1, 32'd0, 1'b0},
            '{KIND_LOAD,  11'd3,    11'd2047, 32'h0000_0000, 1, 32'd0, 1'b0},
            '{KIND_LOAD,  11'd4,    11'd0,    32'hffff_ffff, 1, 32'd0, 1'b0},
            '{KIND_LOAD,  11'd0,    11'd0,    32'h0000_0005, 1, 32'd0, 1'b0},
            '{KIND_LOAD,  11'd5,    11'd0,    32'h0000_0007, 1, 32'd0, 1'b0},
            '{KIND_LOAD,  11'd2047, 11'd2047, 32'hffff_ffff, 1, 32'd0, 1'b0},
            '{2'd3,       11'd1,    11'd4,    32'h0000_0009, 1, 32'd0, 1'b0},
            '{KIND_QUERY, 11'd1,    11'd4,    32'h0,         0, 32'd0, 1'b0},
            '{KIND_QUERY, 11'd3,    11'd2,    32'h0,         1, EMPTY_MIN, 1'b1},
            '{KIND_QUERY, 11'd0,    11'd0,    32'h0,         1, EMPTY_MIN, 1'b1},
            '{KIND_QUERY, 11'd5,    11'd2047, 32'h0,         1, EMPTY_MIN, 1'b1},
            '{KIND_ADD,   11'd0,    11'd2047, 32'h0000_0001, 1, 32'd0, 1'b0},
            '{KIND_QUERY, 11'd2,    11'd2,    32'h0,         0, 32'd0, 1'b0},
            '{KIND_QUERY, 11'd0,    11'd2047, 32'h0,         0, 32'd0, 1'b0},
            '{KIND_ADD,   11'd2,    11'd3,    32'h8000_0000, 1, 32'd0, 1'b0},
            '{KIND_QUERY, 11'd1,    11'd4,    32'h0,         0, 32'd0, 1'b0},
            '{KIND_ADD,   11'd4,    11'd4,    32'h7fff_ffff, 1, 32'd0, 1'b0},
            '{KIND_QUERY, 11'd3,    11'd4,    32'h0,         0, 32'd0, 1'b0},
            '{KIND_ADD,   11'd3,    11'd2,    32'h0000_0005, 1, 32'd0, 1'b0},
            '{KIND_QUERY, 11'd1,    11'd1,    32'h0,         0, 32'd0, 1'b0}
        };
        for (int i = 0; i < TREE_NODES; i++) begin
            node_min[i] = 0;
            node_add[i] = 0;
        end
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed table on a four-position tree.
        write_size(11'd4);
        foreach (rows[i]) begin
            ans = '{minimum: rows[i].minimum, was_query: rows[i].was_query};
            send_item(rows[i].kind, rows[i].lo, rows[i].hi, rows[i].value,
                      rows[i].typed, ans);
        end
        drain();

        // Random phases over several sizes, extremes included.
        run_phase(11'd0, 110);
        run_phase(11'd2047, 140);
        run_phase(11'd1, 100);
        run_phase(11'd2, 100);
        run_phase(11'd100, 120);
        run_phase(11'd37, 120);
        quiet = 1'b1;
        run_phase(11'd17, 120);

        if (error_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

`default_nettype wire
